[rtl/insertion_sorter_with_payloads_macros.svh]
// Assertion macros shared by the sorter RTL.
`ifndef INSERTION_SORTER_WITH_PAYLOADS_MACROS_SVH
`define INSERTION_SORTER_WITH_PAYLOADS_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ISORT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("isort assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ISORT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("isort assertion failed");

`endif

[rtl/isort_pkg.sv]
package isort_pkg;

   localparam int MAX_ITEMS_DEF = 32;
   localparam int WORD_W        = 32;

   typedef struct packed {
      logic signed [WORD_W-1:0] sort_key;
      logic signed [WORD_W-1:0] payload_a;
      logic signed [WORD_W-1:0] payload_b;
      logic                     batch_end;
   } isort_req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] out_key;
      logic signed [WORD_W-1:0] out_payload_a;
      logic signed [WORD_W-1:0] out_payload_b;
      logic                     out_last;
      logic                     overflowed;
   } isort_rsp_type;

   // One stored item as it sits in a cell.
   typedef struct packed {
      logic signed [WORD_W-1:0] key;
      logic signed [WORD_W-1:0] payload_a;
      logic signed [WORD_W-1:0] payload_b;
   } isort_entry_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic insert;
      logic shift;
   } isort_ctl_type;

   typedef enum logic [0:0] {
      ST_LOAD,
      ST_EMIT
   } isort_state_type;

endpackage

[rtl/isort_cell.sv]
module isort_cell (
   input  logic                      clock,
   input  isort_pkg::isort_ctl_type   ctl,
   input  isort_pkg::isort_entry_type new_entry,
   input  isort_pkg::isort_entry_type left_entry,
   input  isort_pkg::isort_entry_type right_entry,
   input  logic                      left_gt,
   input  logic                      occupied,
   output isort_pkg::isort_entry_type entry,
   output logic                      gt
);

   isort_pkg::isort_entry_type entry_ff;
   isort_pkg::isort_entry_type entry_in;

   // An empty cell counts as holding a key above everything.
   assign gt = !occupied || (entry_ff.key > new_entry.key);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift) begin
         entry_in = right_entry;
      end else if (ctl.insert) begin
         if (left_gt) begin
            entry_in = left_entry;
         end else if (gt) begin
            entry_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[rtl/insertion_sorter_with_payloads.sv]
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+------------------------------
// req       | in        | req_valid/req_ready | isort_req_type (key, a, b, end)
// rsp       | out       | rsp_valid/rsp_ready | isort_rsp_type (key, a, b, last, ovf)
//
// While loading, every cell compares its key with the
// arriving one at once and the chain shifts right by one above the insertion
// point. After an item with batch_end the block stops taking items and emits
// one result per cycle from the head of the chain while rsp_ready stays high.
// Reset clears the fill count, the overflow flag, the state and the output
// valid; the cells need no reset. A stall on rsp freezes the chain, and items
// are refused until emission ends.

`include "insertion_sorter_with_payloads_macros.svh"

module insertion_sorter_with_payloads #(
   parameter int MAX_ITEMS = isort_pkg::MAX_ITEMS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  isort_pkg::isort_req_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output isort_pkg::isort_rsp_type rsp_data
);

   localparam int CntW = $clog2(MAX_ITEMS + 1);

   isort_pkg::isort_state_type state_ff;
   isort_pkg::isort_state_type state_in;

   logic [CntW-1:0] fill_ff;
   logic [CntW-1:0] fill_in;
   logic            ovf_ff;
   logic            ovf_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;

   isort_pkg::isort_rsp_type   rsp_data_ff;
   isort_pkg::isort_rsp_type   rsp_data_in;
   isort_pkg::isort_ctl_type   ctl;
   isort_pkg::isort_entry_type new_entry;

   isort_pkg::isort_entry_type cell_entry [MAX_ITEMS];
   logic [MAX_ITEMS-1:0]       cell_gt;

   logic accept;
   logic full;
   logic out_free;
   logic final_shift;

   // Helpers for the checks at the end of the module.
   logic            batch_idle;
   logic [CntW-1:0] fill_plus_one;

   assign new_entry.key       = req_data.sort_key;
   assign new_entry.payload_a = req_data.payload_a;
   assign new_entry.payload_b = req_data.payload_b;

   assign full        = (fill_ff == CntW'(MAX_ITEMS));
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign final_shift = ctl.shift && (fill_ff == CntW'(1));

   // Next state of the load/emit sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         isort_pkg::ST_LOAD: begin
            if (accept && req_data.batch_end) begin
               state_in = isort_pkg::ST_EMIT;
            end
         end
         isort_pkg::ST_EMIT: begin
            if (final_shift) begin
               state_in = isort_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = isort_pkg::ST_LOAD;
         end
      endcase
   end

   // Sequencer outputs: take items while loading, shift out while emitting.
   always_comb begin
      req_ready  = 1'b0;
      ctl.insert = 1'b0;
      ctl.shift  = 1'b0;
      unique case (state_ff)
         isort_pkg::ST_LOAD: begin
            req_ready  = 1'b1;
            ctl.insert = req_valid && !full;
         end
         isort_pkg::ST_EMIT: begin
            ctl.shift = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // The fill count doubles as the number of results still to emit.
   always_comb begin
      fill_in = fill_ff;
      ovf_in  = ovf_ff;
      if (ctl.insert) begin
         fill_in = fill_ff + CntW'(1);
      end else if (ctl.shift) begin
         fill_in = fill_ff - CntW'(1);
      end
      if (accept && full) begin
         ovf_in = 1'b1;
      end else if (final_shift) begin
         ovf_in = 1'b0;
      end
   end

   // Output register takes the head of the chain as the chain moves left.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctl.shift) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.out_key       = cell_entry[0].key;
         rsp_data_in.out_payload_a = cell_entry[0].payload_a;
         rsp_data_in.out_payload_b = cell_entry[0].payload_b;
         rsp_data_in.out_last      = (fill_ff == CntW'(1));
         rsp_data_in.overflowed    = ovf_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= isort_pkg::ST_LOAD;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The chain of cells. Cell zero holds the smallest key.
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      isort_pkg::isort_entry_type left_entry;
      isort_pkg::isort_entry_type right_entry;
      logic                       left_gt;

      if (i == 0) begin : g_head
         assign left_entry = new_entry;
         assign left_gt    = 1'b0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      isort_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .left_gt     (left_gt),
         .occupied    (fill_ff > CntW'(i)),
         .entry       (cell_entry[i]),
         .gt          (cell_gt[i])
      );
   end

   assign batch_idle    = (state_ff == isort_pkg::ST_LOAD) && (fill_ff == '0) && !ovf_ff;
   assign fill_plus_one = fill_ff + CntW'(1);

   `ISORT_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= CntW'(MAX_ITEMS))
   `ISORT_ASSERT_NOW(a_emit_nonempty, clock, reset, state_ff == isort_pkg::ST_EMIT, fill_ff != '0)
   `ISORT_ASSERT_NEXT(a_batch_clears, clock, reset, final_shift, batch_idle)
   `ISORT_ASSERT_NEXT(a_insert_counts, clock, reset, ctl.insert, fill_ff == $past(fill_plus_one))

endmodule

[verif/tb.sv]
module tb;

   // Depth of the sorting chain; the block is built with its default depth.
   localparam int DEPTH            = isort_pkg::MAX_ITEMS_DEF;
   localparam int RANDOM_ITEMS     = 460;
   localparam int DIRECTED_ROWS    = 23;
   // The receiver stops taking results for a long stretch once, mid-batch, so
   // the chain freezes and the sender is left waiting with an item offered.
   localparam int LONG_HOLD_AT     = 60;
   localparam int LONG_HOLD_CYCLES = 150;
   // This margin, twice the chain depth, covers any stray result.
   localparam int DRAIN_CYCLES     = 2 * DEPTH;
   localparam int TIMEOUT          = 400_000;

   localparam logic signed [isort_pkg::WORD_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [isort_pkg::WORD_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   // One row of the directed part. Where fixed_want is set the result is
   // typed in by hand (a lone item in an empty store comes straight back);
   // every other row is checked against the predictor.
   typedef struct {
      int key;
      int pa;
      int pb;
      bit batch_end;
      bit fixed_want;
      int want_key;
      int want_a;
      int want_b;
      bit want_last;
      bit want_ovf;
   } directed_row_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   isort_pkg::isort_req_type req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   isort_pkg::isort_rsp_type rsp_data;

   insertion_sorter_with_payloads dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Our own copy of the sorted store, kept in step with every accepted item.
   isort_pkg::isort_entry_type sorted_store [DEPTH];
   int                         held_count       = 0;
   bit                         dropped_in_batch = 1'b0;
   isort_pkg::isort_rsp_type   released_results [$];
   // Sorted items that the block still owes us, oldest first.
   isort_pkg::isort_rsp_type   pending_sorted_items [$];
   isort_pkg::isort_rsp_type   oldest_due;
   directed_row_type           directed_rows [DIRECTED_ROWS];

   int items_sent      = 0;
   int batches_drained = 0;
   int overflow_batches = 0;
   int results_checked = 0;
   int fail_count      = 0;

   // Inserts one item behind any equal keys, exactly as the chain does, and
   // on the batch end releases the whole store in order and empties it.
   function automatic void insert_and_drain(isort_pkg::isort_req_type item);
      int slot;
      if (held_count >= DEPTH) begin
         dropped_in_batch = 1'b1;
      end else begin
         slot = held_count;
         while (slot > 0 && sorted_store[slot-1].key > item.sort_key) begin
            sorted_store[slot] = sorted_store[slot-1];
            slot--;
         end
         sorted_store[slot] = '{key: item.sort_key, payload_a: item.payload_a,
                                payload_b: item.payload_b};
         held_count++;
      end
      if (item.batch_end) begin
         for (int i = 0; i < held_count; i++) begin
            released_results.push_back('{out_key: sorted_store[i].key,
                                         out_payload_a: sorted_store[i].payload_a,
                                         out_payload_b: sorted_store[i].payload_b,
                                         out_last: (i == held_count - 1),
                                         overflowed: dropped_in_batch});
         end
         batches_drained++;
         if (dropped_in_batch) begin
            overflow_batches++;
         end
         held_count       = 0;
         dropped_in_batch = 1'b0;
      end
   endfunction

   // Keys are drawn so that duplicates, extremes and the full range all turn
   // up: a narrow band around zero gives plenty of equal keys for stability.
   function automatic logic signed [isort_pkg::WORD_W-1:0] draw_key();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         return $signed($urandom_range(0, 7)) - 4;
      end else if (pick < 5) begin
         case ($urandom_range(0, 3))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return 0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   // Offers one item after the given idle gap, holds it until it is taken and
   // then records what the block now owes. A gap of zero keeps valid high.
   task automatic offer_item(input isort_pkg::isort_req_type item, input int gap,
                             input bit fixed_want,
                             input isort_pkg::isort_rsp_type fixed_rsp);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      insert_and_drain(item);
      if (fixed_want && released_results.size() != 0) begin
         pending_sorted_items.push_back(fixed_rsp);
      end else begin
         foreach (released_results[i]) begin
            pending_sorted_items.push_back(released_results[i]);
         end
      end
      released_results.delete();
   endtask

   function automatic void check_word(string field,
                                      logic signed [isort_pkg::WORD_W-1:0] want,
                                      logic signed [isort_pkg::WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   // Every result taken by the receiver is held against the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_sorted_items.size() == 0) begin
            $error("result with key %0d arrived with nothing owed", rsp_data.out_key);
            fail_count++;
         end else begin
            oldest_due = pending_sorted_items.pop_front();
            results_checked++;
            check_word("out_key", oldest_due.out_key, rsp_data.out_key);
            check_word("out_payload_a", oldest_due.out_payload_a, rsp_data.out_payload_a);
            check_word("out_payload_b", oldest_due.out_payload_b, rsp_data.out_payload_b);
            check_word("out_last", 32'(oldest_due.out_last), 32'(rsp_data.out_last));
            check_word("overflowed", 32'(oldest_due.overflowed),
                       32'(rsp_data.overflowed));
         end
      end
   end

   // Receiver: it stalls a random number of cycles before each result, with
   // runs of results taken back to back, and once holds off for a long time.
   initial begin
      int stall;
      bit steady;
      int taken;
      taken  = 0;
      steady = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 16 == 0) begin
            steady = ($urandom_range(0, 2) == 0);
         end
         stall = steady ? 0 : $urandom_range(0, 9);
         if (taken == LONG_HOLD_AT) begin
            stall = LONG_HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // Sender: the directed table first, then random batches.
   initial begin
      isort_pkg::isort_req_type item;
      isort_pkg::isort_rsp_type fixed_rsp;
      int                       batch_len;
      int                       batch_no;
      int                       random_items;
      int                       gap;
      int                       pick;
      bit                       quiet;

      directed_rows = '{
         // Lone items in an empty store: extremes of every field.
         '{KEY_MIN, KEY_MAX, KEY_MIN, 1, 1, KEY_MIN, KEY_MAX, KEY_MIN, 1, 0},
         '{KEY_MAX, 0, -1, 1, 1, KEY_MAX, 0, -1, 1, 0},
         '{0, KEY_MIN, KEY_MAX, 1, 1, 0, KEY_MIN, KEY_MAX, 1, 0},
         '{-1, 32'sh5555_5555, 32'shAAAA_AAAA, 1, 1,
           -1, 32'sh5555_5555, 32'shAAAA_AAAA, 1, 0},
         // Repeated keys: the payloads show that later arrivals stay behind.
         '{5, 1, 101, 0, 0, 0, 0, 0, 0, 0},
         '{-3, 2, 102, 0, 0, 0, 0, 0, 0, 0},
         '{5, 3, 103, 0, 0, 0, 0, 0, 0, 0},
         '{KEY_MAX, 4, 104, 0, 0, 0, 0, 0, 0, 0},
         '{KEY_MIN, 5, 105, 0, 0, 0, 0, 0, 0, 0},
         '{5, 6, 106, 0, 0, 0, 0, 0, 0, 0},
         '{-3, 7, 107, 0, 0, 0, 0, 0, 0, 0},
         '{KEY_MAX, 8, 108, 1, 0, 0, 0, 0, 0, 0},
         // Strictly descending keys: every item goes to the head.
         '{100, 9, 109, 0, 0, 0, 0, 0, 0, 0},
         '{50, 10, 110, 0, 0, 0, 0, 0, 0, 0},
         '{0, 11, 111, 0, 0, 0, 0, 0, 0, 0},
         '{-50, 12, 112, 0, 0, 0, 0, 0, 0, 0},
         '{-100, 13, 113, 1, 0, 0, 0, 0, 0, 0},
         // All keys equal: arrival order must survive untouched.
         '{7, 14, 114, 0, 0, 0, 0, 0, 0, 0},
         '{7, 15, 115, 0, 0, 0, 0, 0, 0, 0},
         '{7, 16, 116, 0, 0, 0, 0, 0, 0, 0},
         '{7, 17, 117, 1, 0, 0, 0, 0, 0, 0},
         // Opposite extremes, the closing one landing in front.
         '{KEY_MAX, 18, 118, 0, 0, 0, 0, 0, 0, 0},
         '{KEY_MIN, 19, 119, 1, 0, 0, 0, 0, 0, 0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         item      = '{sort_key: directed_rows[r].key, payload_a: directed_rows[r].pa,
                       payload_b: directed_rows[r].pb, batch_end: directed_rows[r].batch_end};
         fixed_rsp = '{out_key: directed_rows[r].want_key,
                       out_payload_a: directed_rows[r].want_a,
                       out_payload_b: directed_rows[r].want_b,
                       out_last: directed_rows[r].want_last,
                       overflowed: directed_rows[r].want_ovf};
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 9);
         offer_item(item, gap, directed_rows[r].fixed_want, fixed_rsp);
      end

      // The first random batches fill the store exactly, then overfill it by
      // one (the closing item itself is dropped) and by several. After that
      // most batches are short, some long, and a few overflow again.
      random_items = 0;
      batch_no     = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (batch_no)
            0: batch_len = DEPTH;
            1: batch_len = DEPTH + 1;
            2: batch_len = DEPTH + 8;
            default: begin
               pick = $urandom_range(0, 99);
               if (pick < 70) begin
                  batch_len = $urandom_range(1, 12);
               end else if (pick < 88) begin
                  batch_len = $urandom_range(13, DEPTH);
               end else begin
                  batch_len = $urandom_range(DEPTH + 1, DEPTH + 8);
               end
            end
         endcase
         quiet = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < batch_len; n++) begin
            item.sort_key  = draw_key();
            item.payload_a = $urandom;
            item.payload_b = $urandom;
            item.batch_end = (n == batch_len - 1);
            gap = quiet ? 0 : $urandom_range(0, 9);
            offer_item(item, gap, 1'b0, '0);
         end
         random_items += batch_len;
         batch_no++;
      end
      req_valid <= 1'b0;

      while (pending_sorted_items.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sorted %0d items in %0d batches, %0d of which overflowed the store;",
               items_sent, batches_drained, overflow_batches);
      $display("%0d results were checked in order, with %0d mismatches.",
               results_checked, fail_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of this stimulus.
   initial begin
      #(TIMEOUT);
      $error("run timed out with %0d results still owed", pending_sorted_items.size());
      $display("Verification failed");
      $finish;
   end

endmodule
